// ===== rtl/whs_pkg.sv =====
package whs_pkg;

  localparam int RANGE_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STAGES   = 14;
  localparam int TABLE_LEN       = 24;
  localparam int PRESCALE_BITS   = 20;
  localparam int TABLE_FRAC      = 30;
  localparam int GAIN_FRAC       = 8;

  // CORDIC datapath widths: readings prescaled by 2^20 grow by about 1.65 * sqrt(2)
  localparam int XW   = RANGE_WIDTH + PRESCALE_BITS + 6;
  localparam int ZW   = TABLE_FRAC + 2;
  localparam int MAGW = ANGLE_FRAC_BITS + 2;

  // speed product widths
  localparam int SPW  = 15;
  localparam int GNW  = 16;
  localparam int DBW  = 14;
  localparam int P1W  = SPW + GNW;
  localparam int P2W  = P1W + MAGW;
  localparam int PSH  = GAIN_FRAC + ANGLE_FRAC_BITS;
  localparam int VW   = P2W - PSH;
  localparam int OW   = 16;

  localparam int CFG_IDXW = 2;
  localparam int CFG_DW   = 16;

  localparam logic [CFG_IDXW-1:0] REG_SENSOR_SPACING = 2'd0;
  localparam logic [CFG_IDXW-1:0] REG_HEADING_GAIN   = 2'd1;
  localparam logic [CFG_IDXW-1:0] REG_BASE_SPEED     = 2'd2;
  localparam logic [CFG_IDXW-1:0] REG_DEADBAND       = 2'd3;

  localparam logic [RANGE_WIDTH-1:0] SENSOR_SPACING_RST = 16'd1638;
  localparam logic [GNW-1:0]         HEADING_GAIN_RST   = 16'd640;
  localparam logic [SPW-1:0]         BASE_SPEED_RST     = 15'd256;
  localparam logic [DBW-1:0]         DEADBAND_RST       = 14'd410;

  typedef struct packed {
    logic                 valid;
    logic                 zero;   // difference was zero: heading is exactly zero
    logic                 lft;    // left side, error negated
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 32'sd843314857;
      5'd1:    v = 32'sd497837829;
      5'd2:    v = 32'sd263043837;
      5'd3:    v = 32'sd133525159;
      5'd4:    v = 32'sd67021687;
      5'd5:    v = 32'sd33543516;
      5'd6:    v = 32'sd16775851;
      5'd7:    v = 32'sd8388437;
      5'd8:    v = 32'sd4194283;
      5'd9:    v = 32'sd2097149;
      5'd10:   v = 32'sd1048576;
      5'd11:   v = 32'sd524288;
      5'd12:   v = 32'sd262144;
      5'd13:   v = 32'sd131072;
      5'd14:   v = 32'sd65536;
      5'd15:   v = 32'sd32768;
      5'd16:   v = 32'sd16384;
      5'd17:   v = 32'sd8192;
      5'd18:   v = 32'sd4096;
      5'd19:   v = 32'sd2048;
      5'd20:   v = 32'sd1024;
      5'd21:   v = 32'sd512;
      5'd22:   v = 32'sd256;
      5'd23:   v = 32'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/whs_cordic_cell.sv =====
module whs_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  whs_pkg::cordic_t cell_in,
  output whs_pkg::cordic_t cell_out
);

  localparam logic signed [whs_pkg::ZW-1:0] ATAN = whs_pkg::atan_q30(5'(STAGE));

  whs_pkg::cordic_t data_r, data_nxt;
  logic signed [whs_pkg::XW-1:0] dx, dy;

  always_comb begin
    dx = cell_in.y >>> STAGE;
    dy = cell_in.x >>> STAGE;
    data_nxt = cell_in;
    // rotate toward y = 0
    if (!cell_in.y[whs_pkg::XW-1]) begin
      data_nxt.x = cell_in.x + dx;
      data_nxt.y = cell_in.y - dy;
      data_nxt.z = cell_in.z + ATAN;
    end else begin
      data_nxt.x = cell_in.x - dx;
      data_nxt.y = cell_in.y + dy;
      data_nxt.z = cell_in.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign cell_out = data_r;

endmodule

// ===== rtl/whs_speed.sv =====
module whs_speed (
  input  logic                         clk,
  input  logic                         rst_n,
  input  whs_pkg::cordic_t             angle_in,
  input  logic [whs_pkg::GNW-1:0]      heading_gain,
  input  logic [whs_pkg::SPW-1:0]      base_speed,
  input  logic [whs_pkg::DBW-1:0]      deadband,
  output logic                         out_valid,
  output logic signed [whs_pkg::OW-1:0] out_right,
  output logic signed [whs_pkg::OW-1:0] out_left
);

  localparam int SH = whs_pkg::TABLE_FRAC - whs_pkg::ANGLE_FRAC_BITS;
  localparam int ZW = whs_pkg::ZW;
  localparam int OW = whs_pkg::OW;

  // stage 1: round, sign, deadband
  logic [ZW-1:0]                 zmag;
  logic [ZW:0]                   rsum;
  logic [whs_pkg::MAGW-1:0]      rmag, mag1_nxt;
  logic                          neg1_nxt;
  logic [whs_pkg::MAGW-1:0]      mag1_r, mag2_r;
  logic                          neg1_r, neg2_r, neg3_r;
  logic                          v1_r, v2_r, v3_r, v4_r;
  logic [whs_pkg::P1W-1:0]       p1_r;
  logic [whs_pkg::P2W-1:0]       p2_r;
  logic [whs_pkg::VW-1:0]        val;
  logic signed [OW-1:0]          pos_val, neg_val;
  logic signed [OW-1:0]          right_r, left_r;

  always_comb begin
    zmag = angle_in.z[ZW-1] ? ZW'(-angle_in.z) : ZW'(angle_in.z);
    rsum = {1'b0, zmag} + ((ZW+1)'(1) << (SH - 1));
    rmag = rsum[SH +: whs_pkg::MAGW];
    neg1_nxt = angle_in.z[ZW-1] ^ angle_in.lft;
    if (angle_in.zero || (rmag < whs_pkg::MAGW'(deadband))) begin
      mag1_nxt = '0;
    end else begin
      mag1_nxt = rmag;
    end
  end

  // stage 4: truncate toward zero and saturate both wheels
  always_comb begin
    val = p2_r[whs_pkg::P2W-1:whs_pkg::PSH];
    if (val > whs_pkg::VW'(32767)) begin
      pos_val = 16'sh7FFF;
    end else begin
      pos_val = val[OW-1:0];
    end
    if (val >= whs_pkg::VW'(32768)) begin
      neg_val = 16'sh8000;
    end else begin
      neg_val = -$signed(val[OW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    mag1_r  <= mag1_nxt;
    neg1_r  <= neg1_nxt;
    p1_r    <= whs_pkg::P1W'(base_speed) * whs_pkg::P1W'(heading_gain);
    mag2_r  <= mag1_r;
    neg2_r  <= neg1_r;
    p2_r    <= whs_pkg::P2W'(p1_r) * whs_pkg::P2W'(mag2_r);
    neg3_r  <= neg2_r;
    right_r <= neg3_r ? neg_val : pos_val;
    left_r  <= neg3_r ? pos_val : neg_val;
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= angle_in.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_right = right_r;
  assign out_left  = left_r;

endmodule

// ===== rtl/wall_heading_steering_top.sv =====
// Wall heading steering: range readings in, differential wheel speeds out.
// Input: pulse start with the side select and the four range readings; busy is
// always low, so a reading set is taken in every cycle that start is high.
// Output: out_valid strobes for one cycle with out_right_wheel_speed and
// out_left_wheel_speed; each transfer appears exactly once, in input order.
// The pipeline is one input register, one cell per CORDIC iteration
// (CORDIC_STAGES capped at 24), then rounding/deadband, two multiplier stages
// and the saturation register. Throughput is one reading set per cycle, set
// by the fully pipelined cell row.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 spacing,
// 1 gain, 2 base speed, 3 deadband) at once; write only while no transfer is in
// flight. Reset (rst_n low, synchronous) loads the default registers and
// empties the pipeline; nothing in flight survives it. The receiver cannot
// stall, so results are never held back.
module wall_heading_steering_top #(
  parameter int CORDIC_STAGES = whs_pkg::CORDIC_STAGES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_side,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]    in_right_first_range,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]    in_right_second_range,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]    in_left_first_range,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]    in_left_second_range,
  output logic                               out_valid,
  output logic signed [whs_pkg::OW-1:0]      out_right_wheel_speed,
  output logic signed [whs_pkg::OW-1:0]      out_left_wheel_speed,
  input  logic                               cfg_we,
  input  logic [whs_pkg::CFG_IDXW-1:0]       cfg_index,
  input  logic [whs_pkg::CFG_DW-1:0]         cfg_wdata
);

  localparam int NUM = (CORDIC_STAGES > whs_pkg::TABLE_LEN) ? whs_pkg::TABLE_LEN
                                                            : CORDIC_STAGES;
  localparam int LAT = NUM + 5;
  localparam int RW  = whs_pkg::RANGE_WIDTH;
  localparam int XW  = whs_pkg::XW;

  logic [RW-1:0]              sensor_spacing_r;
  logic [whs_pkg::GNW-1:0]    heading_gain_r;
  logic [whs_pkg::SPW-1:0]    base_speed_r;
  logic [whs_pkg::DBW-1:0]    deadband_r;

  logic [RW-1:0]              first, second;
  logic signed [RW:0]         diff;
  whs_pkg::cordic_t           pre_r, pre_nxt;
  whs_pkg::cordic_t           chain [NUM+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_spacing_r <= whs_pkg::SENSOR_SPACING_RST;
      heading_gain_r   <= whs_pkg::HEADING_GAIN_RST;
      base_speed_r     <= whs_pkg::BASE_SPEED_RST;
      deadband_r       <= whs_pkg::DEADBAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        whs_pkg::REG_SENSOR_SPACING: sensor_spacing_r <= cfg_wdata[RW-1:0];
        whs_pkg::REG_HEADING_GAIN:   heading_gain_r   <= cfg_wdata[whs_pkg::GNW-1:0];
        whs_pkg::REG_BASE_SPEED:     base_speed_r     <= cfg_wdata[whs_pkg::SPW-1:0];
        whs_pkg::REG_DEADBAND:       deadband_r       <= cfg_wdata[whs_pkg::DBW-1:0];
        default: ;
      endcase
    end
  end

  // side select and prescale into the first cell
  always_comb begin
    first  = in_side ? in_left_first_range  : in_right_first_range;
    second = in_side ? in_left_second_range : in_right_second_range;
    diff   = $signed({1'b0, second}) - $signed({1'b0, first});
    pre_nxt.valid = start && !busy;
    pre_nxt.zero  = (diff == '0);
    pre_nxt.lft   = in_side;
    pre_nxt.x     = $signed(XW'(sensor_spacing_r)) <<< whs_pkg::PRESCALE_BITS;
    pre_nxt.y     = XW'(diff) <<< whs_pkg::PRESCALE_BITS;
    pre_nxt.z     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r <= '0;
    end else begin
      pre_r <= pre_nxt;
    end
  end

  assign chain[0] = pre_r;

  for (genvar g = 0; g < NUM; g++) begin : g_cell
    whs_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_in  (chain[g]),
      .cell_out (chain[g+1])
    );
  end

  whs_speed u_speed (
    .clk          (clk),
    .rst_n        (rst_n),
    .angle_in     (chain[NUM]),
    .heading_gain (heading_gain_r),
    .base_speed   (base_speed_r),
    .deadband     (deadband_r),
    .out_valid    (out_valid),
    .out_right    (out_right_wheel_speed),
    .out_left     (out_left_wheel_speed)
  );

`ifndef SYNTH
  a_valid_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a matching input transfer");

  a_wheels_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_wheel_speed == -out_right_wheel_speed) ||
                  (out_right_wheel_speed == 16'sh7FFF && out_left_wheel_speed == 16'sh8000) ||
                  (out_right_wheel_speed == 16'sh8000 && out_left_wheel_speed == 16'sh7FFF))
    else $error("wheel speeds are not negations of each other");

  a_reset_flushes: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
`endif

endmodule

// ===== bench/whs_speed_checker.sv =====
`timescale 1ns / 100ps

module whs_speed_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 in_side,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]      in_right_first_range,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]      in_right_second_range,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]      in_left_first_range,
  input  logic [whs_pkg::RANGE_WIDTH-1:0]      in_left_second_range,
  input  logic                                 out_valid,
  input  logic signed [whs_pkg::OW-1:0]        out_right_wheel_speed,
  input  logic signed [whs_pkg::OW-1:0]        out_left_wheel_speed,
  input  logic                                 cfg_we,
  input  logic [whs_pkg::CFG_IDXW-1:0]         cfg_index,
  input  logic [whs_pkg::CFG_DW-1:0]           cfg_wdata,
  output int                                   mismatches,
  output int                                   outstanding,
  output int                                   results_seen
);

  localparam int STAGES = (whs_pkg::CORDIC_STAGES > whs_pkg::TABLE_LEN) ? whs_pkg::TABLE_LEN
                                                                        : whs_pkg::CORDIC_STAGES;
  localparam int RW = whs_pkg::RANGE_WIDTH;
  localparam int OW = whs_pkg::OW;

  typedef struct packed {
    logic signed [OW-1:0] right;
    logic signed [OW-1:0] left;
  } wheel_speeds_t;

  wheel_speeds_t speed_q[$];

  logic [RW-1:0]           spacing;
  logic [whs_pkg::GNW-1:0] gain;
  logic [whs_pkg::SPW-1:0] base;
  logic [whs_pkg::DBW-1:0] dead;

  // atan(2^-i), Q30
  longint rot_angle [0:whs_pkg::TABLE_LEN-1] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128
  };

  // atan2(dy, dx) by vectoring CORDIC, rounded half away from zero to Q2.13
  function automatic longint wall_angle(longint dy, longint dx);
    longint x, y, z, sx, sy, mag, r;
    int     sh;
    sh = whs_pkg::TABLE_FRAC - whs_pkg::ANGLE_FRAC_BITS;
    if (dy == 0) return 0;
    x = dx <<< whs_pkg::PRESCALE_BITS;
    y = dy <<< whs_pkg::PRESCALE_BITS;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y >= 0) begin
        x = x + sx;
        y = y - sy;
        z = z + rot_angle[i];
      end else begin
        x = x - sx;
        y = y + sy;
        z = z - rot_angle[i];
      end
    end
    mag = (z < 0) ? -z : z;
    r = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return (z < 0) ? -r : r;
  endfunction

  function automatic logic signed [OW-1:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[OW-1:0];
  endfunction

  function automatic wheel_speeds_t steer_speeds(logic side, logic [RW-1:0] rf,
                                                 logic [RW-1:0] rs,
                                                 logic [RW-1:0] lf,
                                                 logic [RW-1:0] ls);
    longint        first, second, err, mag, val;
    wheel_speeds_t s;
    first  = side ? longint'(lf) : longint'(rf);
    second = side ? longint'(ls) : longint'(rs);
    err = wall_angle(second - first, longint'(spacing));
    if (side) err = -err;
    mag = (err < 0) ? -err : err;
    if (mag < longint'(dead)) begin
      err = 0;
      mag = 0;
    end
    // truncation toward zero: shift the magnitude, then apply the sign
    val = (longint'(base) * longint'(gain) * mag) >>> whs_pkg::PSH;
    if (err < 0) val = -val;
    s.right = clamp16(val);
    s.left  = clamp16(-val);
    return s;
  endfunction

  always @(posedge clk) begin
    wheel_speeds_t want;
    int            errs;
    errs = 0;
    if (!rst_n) begin
      spacing      <= whs_pkg::SENSOR_SPACING_RST;
      gain         <= whs_pkg::HEADING_GAIN_RST;
      base         <= whs_pkg::BASE_SPEED_RST;
      dead         <= whs_pkg::DEADBAND_RST;
      speed_q.delete();
      outstanding  <= 0;
      mismatches   <= 0;
      results_seen <= 0;
    end else begin
      // result side first: an output at this edge belongs to an older reading set
      if (out_valid) begin
        if (speed_q.size() == 0) begin
          $error("result transfer with no reading set outstanding: right %0d left %0d",
                 out_right_wheel_speed, out_left_wheel_speed);
          errs++;
        end else begin
          want = speed_q.pop_front();
          if (out_right_wheel_speed !== want.right) begin
            $error("right_wheel_speed: expected %0d, got %0d", want.right,
                   out_right_wheel_speed);
            errs++;
          end
          if (out_left_wheel_speed !== want.left) begin
            $error("left_wheel_speed: expected %0d, got %0d", want.left,
                   out_left_wheel_speed);
            errs++;
          end
        end
      end
      if (start && !busy)
        speed_q.push_back(steer_speeds(in_side, in_right_first_range, in_right_second_range,
                                       in_left_first_range, in_left_second_range));
      if (cfg_we) begin
        case (cfg_index)
          whs_pkg::REG_SENSOR_SPACING: spacing <= cfg_wdata[RW-1:0];
          whs_pkg::REG_HEADING_GAIN:   gain    <= cfg_wdata[whs_pkg::GNW-1:0];
          whs_pkg::REG_BASE_SPEED:     base    <= cfg_wdata[whs_pkg::SPW-1:0];
          whs_pkg::REG_DEADBAND:       dead    <= cfg_wdata[whs_pkg::DBW-1:0];
          default: ;
        endcase
      end
      outstanding  <= speed_q.size();
      mismatches   <= mismatches + errs;
      results_seen <= results_seen + (out_valid ? 1 : 0);
    end
  end

endmodule

// ===== bench/tb_wall_heading_steering_top.sv =====
`timescale 1ns / 100ps

module tb_wall_heading_steering_top;

  localparam int PIPE_LAT  = ((whs_pkg::CORDIC_STAGES > whs_pkg::TABLE_LEN) ?
                              whs_pkg::TABLE_LEN : whs_pkg::CORDIC_STAGES) + 5;
  localparam int NUM_SET   = 8;
  localparam int PER_SET   = 112;
  localparam int NUM_RAND  = NUM_SET * PER_SET;
  localparam int RW        = whs_pkg::RANGE_WIDTH;
  localparam int DW        = whs_pkg::CFG_DW;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_side;
  logic [RW-1:0] in_right_first_range;
  logic [RW-1:0] in_right_second_range;
  logic [RW-1:0] in_left_first_range;
  logic [RW-1:0] in_left_second_range;
  logic out_valid;
  logic signed [whs_pkg::OW-1:0] out_right_wheel_speed;
  logic signed [whs_pkg::OW-1:0] out_left_wheel_speed;
  logic cfg_we;
  logic [whs_pkg::CFG_IDXW-1:0] cfg_index;
  logic [DW-1:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int readings_sent = 0;
  int idle_pct = 0;
  int settings_loaded = 1;   // reset values count as one

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wall_heading_steering_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_side               (in_side),
    .in_right_first_range  (in_right_first_range),
    .in_right_second_range (in_right_second_range),
    .in_left_first_range   (in_left_first_range),
    .in_left_second_range  (in_left_second_range),
    .out_valid             (out_valid),
    .out_right_wheel_speed (out_right_wheel_speed),
    .out_left_wheel_speed  (out_left_wheel_speed),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  whs_speed_checker u_chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_side               (in_side),
    .in_right_first_range  (in_right_first_range),
    .in_right_second_range (in_right_second_range),
    .in_left_first_range   (in_left_first_range),
    .in_left_second_range  (in_left_second_range),
    .out_valid             (out_valid),
    .out_right_wheel_speed (out_right_wheel_speed),
    .out_left_wheel_speed  (out_left_wheel_speed),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .mismatches            (mismatches),
    .outstanding           (outstanding),
    .results_seen          (results_seen)
  );

  // one reading-set transfer; start stays high when the next set follows at once
  task automatic send_reading(input logic side, input logic [RW-1:0] rf,
                              input logic [RW-1:0] rs,
                              input logic [RW-1:0] lf,
                              input logic [RW-1:0] ls);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99, 0) < idle_pct) begin
      if (!lowered) start <= 1'b0;
      lowered = 1'b1;
      @(negedge clk);
    end
    in_side               <= side;
    in_right_first_range  <= rf;
    in_right_second_range <= rs;
    in_left_first_range   <= lf;
    in_left_second_range  <= ls;
    start                 <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    readings_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_reading();
    int   a, b, d, mode;
    logic side;
    side = 1'($urandom_range(1, 0));
    a    = $urandom_range(65535, 0);
    mode = $urandom_range(9, 0);
    case (mode)
      0, 1, 2: b = $urandom_range(65535, 0);
      3, 4, 5: begin
        d = $urandom_range(1024, 0) - 512;
        b = a + d;
      end
      6: begin
        d = $urandom_range(8192, 0) - 4096;
        b = a + d;
      end
      7: b = a;
      8: begin
        a = $urandom_range(1, 0) ? 65535 : 0;
        b = $urandom_range(1, 0) ? 65535 : 0;
      end
      default: begin
        // small differences that straddle the deadband
        d = $urandom_range(256, 0) - 128;
        b = a + d;
      end
    endcase
    if (b < 0) b = 0;
    if (b > 65535) b = 65535;
    if (side)
      send_reading(side, 16'($urandom), 16'($urandom), 16'(a), 16'(b));
    else
      send_reading(side, 16'(a), 16'(b), 16'($urandom), 16'($urandom));
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic load_settings(input logic [DW-1:0] sp, input logic [DW-1:0] gn,
                               input logic [DW-1:0] bs, input logic [DW-1:0] db);
    cfg_we    <= 1'b1;
    cfg_index <= whs_pkg::REG_SENSOR_SPACING;
    cfg_wdata <= sp;
    @(negedge clk);
    cfg_index <= whs_pkg::REG_HEADING_GAIN;
    cfg_wdata <= gn;
    @(negedge clk);
    cfg_index <= whs_pkg::REG_BASE_SPEED;
    cfg_wdata <= bs;
    @(negedge clk);
    cfg_index <= whs_pkg::REG_DEADBAND;
    cfg_wdata <= db;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    #2_000_000;
    $display("tb_wall_heading_steering_top: FAIL");
    $finish;
  end

  initial begin
    logic [DW-1:0] sp, gn, bs, db;
    int r;
    rst_n                 = 1'b0;
    start                 = 1'b0;
    in_side               = 1'b0;
    in_right_first_range  = '0;
    in_right_second_range = '0;
    in_left_first_range   = '0;
    in_left_second_range  = '0;
    cfg_we                = 1'b0;
    cfg_index             = whs_pkg::REG_SENSOR_SPACING;
    cfg_wdata             = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed sets at reset settings
    idle_pct = 6;
    send_reading(1'b0, 16'd1000, 16'd1000, 16'd0, 16'd65535);
    send_reading(1'b0, 16'd0, 16'd65535, 16'd0, 16'd0);
    send_reading(1'b0, 16'd65535, 16'd0, 16'd0, 16'd0);
    send_reading(1'b1, 16'd0, 16'd65535, 16'd40000, 16'd40000);
    send_reading(1'b1, 16'd0, 16'd0, 16'd0, 16'd65535);
    send_reading(1'b1, 16'd0, 16'd0, 16'd65535, 16'd0);
    send_reading(1'b0, 16'd5000, 16'd5080, 16'd0, 16'd0);
    send_reading(1'b0, 16'd5000, 16'd5090, 16'd0, 16'd0);
    send_reading(1'b0, 16'd5080, 16'd5000, 16'd0, 16'd0);
    send_reading(1'b0, 16'd5090, 16'd5000, 16'd0, 16'd0);
    send_reading(1'b1, 16'd0, 16'd0, 16'd7000, 16'd7082);
    send_reading(1'b1, 16'd0, 16'd0, 16'd7082, 16'd7000);
    send_reading(1'b0, 16'd65535, 16'd65535, 16'd0, 16'd65535);
    send_reading(1'b1, 16'd0, 16'd65535, 16'd65535, 16'd65535);
    send_reading(1'b0, 16'd1, 16'd0, 16'd65535, 16'd65535);
    send_reading(1'b1, 16'd65535, 16'd65535, 16'd0, 16'd1);

    for (int k = 0; k < NUM_SET; k++) begin
      drain();
      case (k)
        0: begin sp = 16'd1638;  gn = 16'd640;   bs = 16'd256;   db = 16'd410;   end
        1: begin sp = 16'd1;     gn = 16'hffff;  bs = 16'hffff;  db = 16'd0;     end
        2: begin sp = 16'hffff;  gn = 16'd256;   bs = 16'd1000;  db = 16'd12868; end
        3: begin sp = 16'd0;     gn = 16'd640;   bs = 16'd256;   db = 16'd410;   end
        4: begin sp = 16'd100;   gn = 16'd0;     bs = 16'd32767; db = 16'hffff;  end
        6: begin sp = 16'd4096;  gn = 16'd1;     bs = 16'd1;     db = 16'd1;     end
        default: begin
          sp = 16'($urandom);
          gn = 16'($urandom);
          bs = 16'($urandom);
          db = 16'($urandom_range(2000, 0));
        end
      endcase
      load_settings(sp, gn, bs, db);
      for (int j = 0; j < PER_SET; j++) begin
        r = k * PER_SET + j;
        idle_pct = (r < NUM_RAND / 3) ? 6 : (r < 2 * NUM_RAND / 3) ? 75 : 0;
        send_random_reading();
      end
    end

    drain();
    repeat (2 * PIPE_LAT) @(negedge clk);
    $display("covered %0d reading sets under %0d register settings, %0d results checked",
             readings_sent, settings_loaded, results_seen);
    $display("sender idle profiles 6%%, 75%% and none; zero spacing and saturation included");
    if (mismatches == 0 && outstanding == 0)
      $display("tb_wall_heading_steering_top: PASS");
    else
      $display("tb_wall_heading_steering_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/whs_pkg.sv
rtl/whs_cordic_cell.sv
rtl/whs_speed.sv
rtl/wall_heading_steering_top.sv
bench/whs_speed_checker.sv
bench/tb_wall_heading_steering_top.sv
